### hw/rtl/ctp_pkg.sv
// Shared types and constants for the couplet token parser.
package ctp_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned INDEX_W = 6;
   localparam int unsigned CODE_W  = 2 * INDEX_W;
   localparam int unsigned CSR_INDEX_W = 8;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIMITER = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARKER    = 8'd1;

   localparam logic [CHAR_W-1:0] DELIMITER_RESET = 8'd46;
   localparam logic [CHAR_W-1:0] MARKER_RESET    = 8'd42;

   // queue between the classifier and the result stage
   localparam int unsigned QDEPTH  = 2;
   localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int unsigned QCOUNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [INDEX_W-1:0] lead_index;
      logic [INDEX_W-1:0] second_index;
      logic               partial;
      logic               last;
      logic               error;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

endpackage

### hw/rtl/ctp_front.sv
// Classifier: takes characters, tracks the part position and builds result jobs.
module ctp_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [ctp_pkg::CHAR_W-1:0]   req_ch,
   input  logic                         req_is_end,
   output logic                         req_stall,
   input  logic [ctp_pkg::CHAR_W-1:0]   delimiter,
   input  logic [ctp_pkg::CHAR_W-1:0]   marker,
   input  logic                         queue_full,
   output ctp_pkg::push_type            push
);

   localparam logic [ctp_pkg::CHAR_W-1:0] CHAR_DASH  = 8'h2D;
   localparam logic [ctp_pkg::CHAR_W-1:0] CHAR_UNDER = 8'h5F;
   localparam logic [1:0] POS_EMPTY = 2'd0;
   localparam logic [1:0] POS_ONE   = 2'd1;
   localparam logic [1:0] POS_TWO   = 2'd2;

   // bit 6 set: not in the alphabet
   function automatic logic [ctp_pkg::INDEX_W:0] lookup(input logic [ctp_pkg::CHAR_W-1:0] c);
      logic [ctp_pkg::INDEX_W:0] r;
      r = 7'd64;
      priority if (c >= 8'h41 && c <= 8'h5A) r = 7'(c - 8'h41);
      else if (c >= 8'h61 && c <= 8'h7A) r = 7'(c - 8'h61 + 8'd26);
      else if (c >= 8'h30 && c <= 8'h39) r = 7'(c - 8'h30 + 8'd52);
      else if (c == CHAR_DASH) r = 7'd62;
      else if (c == CHAR_UNDER) r = 7'd63;
      else r = 7'd64;
      return r;
   endfunction

   logic [1:0]                 pos_ff, pos_in;
   logic [ctp_pkg::CHAR_W-1:0] first_ff, first_in;
   logic [ctp_pkg::CHAR_W-1:0] second_ff, second_in;
   logic                       err_ff, err_in;

   logic                       accept;
   logic                       is_delim;
   logic [ctp_pkg::CHAR_W-1:0] second_sel;
   logic [ctp_pkg::INDEX_W:0]  a_lk, b_lk;
   logic                       sel_partial;
   logic                       elem_ok_mid, elem_ok_end;
   ctp_pkg::job_type           elem_job, err_job;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~req_stall;
   assign is_delim  = (req_ch == delimiter);

   // on a delimiter the part is the two held characters, at the end it is held + this one
   assign second_sel  = is_delim ? second_ff : req_ch;
   assign a_lk        = lookup(first_ff);
   assign b_lk        = lookup(second_sel);
   assign sel_partial = (second_sel == marker);
   assign elem_ok_mid = ~sel_partial & ~a_lk[ctp_pkg::INDEX_W] & ~b_lk[ctp_pkg::INDEX_W];
   assign elem_ok_end = ~a_lk[ctp_pkg::INDEX_W] & (sel_partial | ~b_lk[ctp_pkg::INDEX_W]);

   always_comb begin
      elem_job.lead_index   = a_lk[ctp_pkg::INDEX_W-1:0];
      elem_job.second_index = sel_partial ? '0 : b_lk[ctp_pkg::INDEX_W-1:0];
      elem_job.partial      = sel_partial;
      elem_job.last         = ~is_delim;
      elem_job.error        = 1'b0;
      err_job               = '0;
      err_job.last          = 1'b1;
      err_job.error         = 1'b1;
   end

   always_comb begin
      pos_in     = pos_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      err_in     = err_ff;
      push.valid = 1'b0;
      push.job   = err_job;
      if (accept) begin
         priority if (err_ff) begin
            if (req_is_end) begin
               push.valid = 1'b1;
               pos_in = POS_EMPTY; first_in = '0; second_in = '0; err_in = 1'b0;
            end
         end else if (is_delim) begin
            if (req_is_end) begin
               push.valid = 1'b1;
               pos_in = POS_EMPTY; first_in = '0; second_in = '0; err_in = 1'b0;
            end else if (pos_ff != POS_TWO || !elem_ok_mid) begin
               err_in = 1'b1;
               pos_in = POS_EMPTY;
            end else begin
               push.valid = 1'b1;
               push.job   = elem_job;
               pos_in = POS_EMPTY; first_in = '0; second_in = '0;
            end
         end else if (pos_ff == POS_TWO) begin
            if (req_is_end) begin
               push.valid = 1'b1;
               pos_in = POS_EMPTY; first_in = '0; second_in = '0; err_in = 1'b0;
            end else begin
               err_in = 1'b1;
            end
         end else begin
            if (pos_ff == POS_EMPTY) first_in = req_ch;
            else second_in = req_ch;
            pos_in = (pos_ff == POS_EMPTY) ? POS_ONE : POS_TWO;
            if (req_is_end) begin
               push.valid = 1'b1;
               if (pos_ff == POS_ONE && elem_ok_end) push.job = elem_job;
               pos_in = POS_EMPTY; first_in = '0; second_in = '0; err_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_EMPTY;
         first_ff  <= '0;
         second_ff <= '0;
         err_ff    <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         err_ff    <= err_in;
      end
   end

endmodule

### hw/rtl/ctp_queue.sv
// Short job queue between the classifier and the result stage.
module ctp_queue (
   input  logic              clock,
   input  logic              reset,
   input  ctp_pkg::push_type push,
   input  logic              pop,
   output logic              full,
   output ctp_pkg::head_type head
);

   ctp_pkg::job_type                entry_ff [ctp_pkg::QDEPTH];
   logic [ctp_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [ctp_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [ctp_pkg::QCOUNT_W-1:0]    count_ff, count_in;
   logic                            do_push, do_pop;

   localparam logic [ctp_pkg::QPTR_W-1:0]   PTR_LAST = ctp_pkg::QPTR_W'(ctp_pkg::QDEPTH - 1);
   localparam logic [ctp_pkg::QPTR_W-1:0]   PTR_ONE  = ctp_pkg::QPTR_W'(1);
   localparam logic [ctp_pkg::QCOUNT_W-1:0] COUNT_FULL = ctp_pkg::QCOUNT_W'(ctp_pkg::QDEPTH);
   localparam logic [ctp_pkg::QCOUNT_W-1:0] COUNT_ONE  = ctp_pkg::QCOUNT_W'(1);

   assign full      = (count_ff == COUNT_FULL);
   assign head.valid = (count_ff != '0);
   assign head.job  = entry_ff[rd_ptr_ff];
   assign do_push   = push.valid & ~full;
   assign do_pop    = pop & head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_ONE;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_ONE;
      if (do_push && !do_pop) count_in = count_ff + COUNT_ONE;
      else if (do_pop && !do_push) count_in = count_ff - COUNT_ONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push.job;
   end

`ifndef SYNTH
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full) else $error("job pushed into a full queue");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid) else $error("pop from an empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL) else $error("queue count past depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + COUNT_ONE)
      else $error("queue count did not advance on push");
`endif

endmodule

### hw/rtl/ctp_back.sv
// Result stage: pops jobs and holds the result beat in the output register.
module ctp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  ctp_pkg::head_type             head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ctp_pkg::INDEX_W-1:0]   rsp_lead_index,
   output logic [ctp_pkg::INDEX_W-1:0]   rsp_second_index,
   output logic [ctp_pkg::CODE_W-1:0]    rsp_pair_code,
   output logic                          rsp_partial,
   output logic                          rsp_last,
   output logic                          rsp_error
);

   logic                        valid_ff, valid_in;
   ctp_pkg::job_type            job_ff;
   logic [ctp_pkg::CODE_W-1:0]  code_ff;
   logic                        load;

   assign load     = head.valid & (~valid_ff | ~rsp_stall);
   assign pop      = load;
   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff  <= head.job;
         code_ff <= {head.job.lead_index, head.job.second_index};
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_lead_index   = job_ff.lead_index;
   assign rsp_second_index = job_ff.second_index;
   assign rsp_pair_code    = code_ff;
   assign rsp_partial      = job_ff.partial;
   assign rsp_last         = job_ff.last;
   assign rsp_error        = job_ff.error;

endmodule

### hw/rtl/couplet_token_parser.sv
// Top level of the couplet token parser: csr registers, classifier, queue, result stage.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  req_ch[7:0], req_is_end
//   rsp       out        rsp_valid / rsp_stall  lead/second index, pair code, flags
//   csr       in         csr_valid / csr_ready  csr_index[7:0], csr_data[7:0]
//
// One character is taken per cycle while req_stall is low; the job of the character that
// closes a part goes into the queue, and from the queue into the output register.
// The rate is set by the classifier: one lookup and position update per character.
// Reset is synchronous: position, error flag, queue and output valid clear; the
// delimiter returns to '.' and the marker to '*'.
// A stalled rsp backs jobs into the two-entry queue; req_stall rises only when it is full.
// csr writes are always taken (csr_ready is tied high); unknown indexes are dropped.
module couplet_token_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ctp_pkg::CHAR_W-1:0]        req_ch,
   input  logic                              req_is_end,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ctp_pkg::INDEX_W-1:0]       rsp_lead_index,
   output logic [ctp_pkg::INDEX_W-1:0]       rsp_second_index,
   output logic [ctp_pkg::CODE_W-1:0]        rsp_pair_code,
   output logic                              rsp_partial,
   output logic                              rsp_last,
   output logic                              rsp_error,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ctp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ctp_pkg::CHAR_W-1:0]        csr_data
);

   logic [ctp_pkg::CHAR_W-1:0] delim_ff, delim_in;
   logic [ctp_pkg::CHAR_W-1:0] marker_ff, marker_in;
   logic                       csr_write;

   ctp_pkg::push_type push;
   ctp_pkg::head_type head;
   logic              queue_full;
   logic              pop;

   // csr port never back-pressures
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      delim_in  = delim_ff;
      marker_in = marker_ff;
      if (csr_write) begin
         unique case (csr_index)
            ctp_pkg::CSR_DELIMITER: delim_in  = csr_data;
            ctp_pkg::CSR_MARKER:    marker_in = csr_data;
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff  <= ctp_pkg::DELIMITER_RESET;
         marker_ff <= ctp_pkg::MARKER_RESET;
      end else begin
         delim_ff  <= delim_in;
         marker_ff <= marker_in;
      end
   end

   // classify characters and push one job per finished part or per token end
   ctp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ch     (req_ch),
      .req_is_end (req_is_end),
      .req_stall  (req_stall),
      .delimiter  (delim_ff),
      .marker     (marker_ff),
      .queue_full (queue_full),
      .push       (push)
   );

   // hold jobs while the result side is stalled
   ctp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   // advance jobs into the output register, one beat at a time
   ctp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_lead_index   (rsp_lead_index),
      .rsp_second_index (rsp_second_index),
      .rsp_pair_code    (rsp_pair_code),
      .rsp_partial      (rsp_partial),
      .rsp_last         (rsp_last),
      .rsp_error        (rsp_error)
   );

endmodule

### tb/couplet_token_parser_tb.sv
// Self-checking testbench for the couplet token parser: random tokens, csr phases, stall pressure.
`timescale 1ns / 1ps

module couplet_token_parser_tb;

   localparam int RESET_CYCLES   = 11;
   localparam int DRAIN_CYCLES   = 8;     // result passes the queue and the output reg after its closing char
   localparam int HOLD_CYCLES    = 200;   // long receiver hold-off during the pressure phase
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any accepted beat
   localparam int PHASE_CHARS    = 140;
   localparam int PRINT_LIMIT    = 100;

   // no register here; write is dropped
   localparam logic [ctp_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 8'hFF;
   localparam logic [ctp_pkg::INDEX_W:0]       NOT_IN_ALPHABET = 7'd64;

   typedef enum {TOKEN_GOOD, TOKEN_BROKEN, TOKEN_NOISE} token_kind_type;
   typedef enum {
      FAULT_DROP, FAULT_EXTRA, FAULT_BYTE, FAULT_TRAIL_DELIM, FAULT_EARLY_MARKER, FAULT_SPLIT
   } token_fault_type;

   typedef struct packed {
      logic [ctp_pkg::CHAR_W-1:0] ch;
      logic                       is_end;
   } token_char_type;

   typedef struct packed {
      logic [ctp_pkg::INDEX_W-1:0] lead_index;
      logic [ctp_pkg::INDEX_W-1:0] second_index;
      logic [ctp_pkg::CODE_W-1:0]  pair_code;
      logic                        partial;
      logic                        last;
      logic                        error;
   } couplet_type;

   // DUT ports
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [ctp_pkg::CHAR_W-1:0]      req_ch = '0;
   logic                            req_is_end = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [ctp_pkg::INDEX_W-1:0]     rsp_lead_index;
   logic [ctp_pkg::INDEX_W-1:0]     rsp_second_index;
   logic [ctp_pkg::CODE_W-1:0]      rsp_pair_code;
   logic                            rsp_partial;
   logic                            rsp_last;
   logic                            rsp_error;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [ctp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ctp_pkg::CHAR_W-1:0]      csr_data = '0;

   // chars waiting to be driven, couplets waiting to be seen
   token_char_type             token_chars[$];
   couplet_type                couplets_due[$];
   logic [ctp_pkg::CHAR_W-1:0] draft[$];

   int chars_loaded = 0;
   int chars_taken = 0;
   int results_predicted = 0;
   int results_taken = 0;
   int csr_beats = 0;
   int mismatch_count = 0;
   int send_idle_max = 13;
   int recv_idle_max = 13;
   bit pressure_go = 1'b0;
   logic hold_rsp = 1'b0;

   // shadow of the csr registers, as the block should hold them
   logic [ctp_pkg::CHAR_W-1:0] delim_q = ctp_pkg::DELIMITER_RESET;
   logic [ctp_pkg::CHAR_W-1:0] marker_q = ctp_pkg::MARKER_RESET;

   // predictor copy of the parse state
   logic [1:0]                 tok_pos = '0;
   logic [ctp_pkg::CHAR_W-1:0] tok_first = '0;
   logic [ctp_pkg::CHAR_W-1:0] tok_second = '0;
   logic                       tok_broken = 1'b0;

   couplet_token_parser i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .req_is_end       (req_is_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_lead_index   (rsp_lead_index),
      .rsp_second_index (rsp_second_index),
      .rsp_pair_code    (rsp_pair_code),
      .rsp_partial      (rsp_partial),
      .rsp_last         (rsp_last),
      .rsp_error        (rsp_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   // Map a raw char to its base64url index; anything else gives NOT_IN_ALPHABET.
   function automatic logic [ctp_pkg::INDEX_W:0] b64_index(input logic [ctp_pkg::CHAR_W-1:0] c);
      if (c >= "A" && c <= "Z") return 7'(c - "A");
      if (c >= "a" && c <= "z") return 7'(c - "a" + 8'd26);
      if (c >= "0" && c <= "9") return 7'(c - "0" + 8'd52);
      if (c == "-") return 7'd62;
      if (c == "_") return 7'd63;
      return NOT_IN_ALPHABET;
   endfunction

   function automatic logic [ctp_pkg::CHAR_W-1:0] b64_char(input int unsigned idx);
      int unsigned v;
      if (idx < 26) v = 65 + idx;
      else if (idx < 52) v = 97 + idx - 26;
      else if (idx < 62) v = 48 + idx - 52;
      else if (idx == 62) v = 45;
      else v = 95;
      return v[ctp_pkg::CHAR_W-1:0];
   endfunction

   function automatic void clear_token();
      tok_pos = '0;
      tok_first = '0;
      tok_second = '0;
      tok_broken = 1'b0;
   endfunction

   // Build the couplet for the two held chars; return 0 when the part is malformed.
   // The marker test comes first, so a marker that is also in the alphabet still means partial.
   function automatic bit close_part(input bit closes, output couplet_type elem);
      logic [ctp_pkg::INDEX_W:0] a;
      logic [ctp_pkg::INDEX_W:0] b;
      a = b64_index(tok_first);
      b = b64_index(tok_second);
      elem = '0;
      elem.last = closes;
      elem.lead_index = a[ctp_pkg::INDEX_W-1:0];
      if (tok_second == marker_q) begin
         elem.partial = 1'b1;
         elem.pair_code = {a[ctp_pkg::INDEX_W-1:0], {ctp_pkg::INDEX_W{1'b0}}};
         return closes && a != NOT_IN_ALPHABET;
      end
      elem.second_index = b[ctp_pkg::INDEX_W-1:0];
      elem.pair_code = {a[ctp_pkg::INDEX_W-1:0], b[ctp_pkg::INDEX_W-1:0]};
      return a != NOT_IN_ALPHABET && b != NOT_IN_ALPHABET;
   endfunction

   function automatic void expect_couplet(input couplet_type elem);
      couplets_due.insert(couplets_due.size(), elem);
      results_predicted++;
   endfunction

   // Close the token as malformed: all element fields zero, last and error set.
   function automatic void expect_error();
      couplet_type elem;
      elem = '0;
      elem.last = 1'b1;
      elem.error = 1'b1;
      clear_token();
      expect_couplet(elem);
   endfunction

   // Advance the predicted parse by one accepted char.
   task automatic parse_char(input logic [ctp_pkg::CHAR_W-1:0] ch, input logic is_end);
      couplet_type elem;
      bit made;
      made = 1'b0;
      if (tok_broken) begin
         // drop chars of a bad token until its end
         if (is_end) expect_error();
      end else if (ch == delim_q) begin
         // the delimiter always splits, even when it is also the marker or in the alphabet
         if (!is_end && tok_pos == 2) made = close_part(1'b0, elem);
         if (made) begin
            expect_couplet(elem);
            tok_pos = '0;
            tok_first = '0;
            tok_second = '0;
         end else if (is_end) begin
            expect_error();
         end else begin
            tok_broken = 1'b1;
            tok_pos = '0;
         end
      end else if (tok_pos >= 2) begin
         // third char in one part
         if (is_end) expect_error();
         else tok_broken = 1'b1;
      end else begin
         if (tok_pos == 0) tok_first = ch;
         else tok_second = ch;
         tok_pos = tok_pos + 2'd1;
         if (is_end) begin
            if (tok_pos == 2) made = close_part(1'b1, elem);
            if (made) begin
               expect_couplet(elem);
               clear_token();
            end else begin
               expect_error();
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Driver: feed req beats from token_chars, predict on every accepted beat
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : drive_chars
      token_char_type beat;
      int send_wait;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
         clear_token();
      end else begin
         if (req_valid && !req_stall) begin
            parse_char(req_ch, req_is_end);
            chars_taken++;
         end
         if (req_valid && req_stall) begin
            // hold the stalled beat as it is
         end else if (send_wait > 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (token_chars.size() != 0) begin
            beat = token_chars.pop_front();
            req_valid <= 1'b1;
            req_ch <= beat.ch;
            req_is_end <= beat.is_end;
            // draw the gap in front of the next beat
            send_wait = $urandom_range(0, send_idle_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: compare every accepted rsp beat against the oldest predicted couplet
   // ---------------------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("[%0t] mismatch on result %0d: %s", $realtime, results_taken, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   always @(posedge clock) begin : check_results
      couplet_type want;
      int recv_wait;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_taken++;
            if (couplets_due.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else if ($isunknown({rsp_lead_index, rsp_second_index, rsp_pair_code,
                                     rsp_partial, rsp_last, rsp_error})) begin
               void'(couplets_due.pop_front());
               report_mismatch("unknown bits in result");
            end else begin
               want = couplets_due.pop_front();
               check_field("lead_index", int'(rsp_lead_index), int'(want.lead_index));
               check_field("second_index", int'(rsp_second_index), int'(want.second_index));
               check_field("pair_code", int'(rsp_pair_code), int'(want.pair_code));
               check_field("partial", int'(rsp_partial), int'(want.partial));
               check_field("last", int'(rsp_last), int'(want.last));
               check_field("error", int'(rsp_error), int'(want.error));
            end
            recv_wait = $urandom_range(0, recv_idle_max);
         end
         // the pressure hold-off wins over the per-beat stall
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Track csr writes so the predictor sees the same delimiter and marker as the block.
   always @(posedge clock) begin : track_csr
      if (reset) begin
         delim_q = ctp_pkg::DELIMITER_RESET;
         marker_q = ctp_pkg::MARKER_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ctp_pkg::CSR_DELIMITER: delim_q = csr_data;
            ctp_pkg::CSR_MARKER:    marker_q = csr_data;
            default: ;
         endcase
         csr_beats++;
      end
   end

   // Stop the run when no beat moves on any channel for too long.
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Hold rsp off for a long stretch once, while the sender keeps offering chars,
   // so the queue behind the output fills and req_stall has to rise.
   initial begin : rsp_hold_off
      wait (pressure_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------
   task automatic queue_char(input logic [ctp_pkg::CHAR_W-1:0] ch, input logic is_end);
      token_char_type beat;
      beat.ch = ch;
      beat.is_end = is_end;
      token_chars.insert(token_chars.size(), beat);
      chars_loaded++;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_char(s[i], i == s.len() - 1);
   endtask

   // Well-formed token: 1 to 4 parts mostly, a few long ones, sometimes a partial last part.
   task automatic draft_good();
      int parts;
      parts = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
      draft.delete();
      for (int p = 0; p < parts; p++) begin
         if (p != 0) draft.insert(draft.size(), delim_q);
         draft.insert(draft.size(), b64_char($urandom_range(0, 63)));
         if (p == parts - 1 && $urandom_range(0, 3) == 0) draft.insert(draft.size(), marker_q);
         else draft.insert(draft.size(), b64_char($urandom_range(0, 63)));
      end
   endtask

   // Break a well-formed draft in one place.
   task automatic break_draft();
      token_fault_type fault;
      int at;
      fault = token_fault_type'($urandom_range(0, 5));
      at = $urandom_range(0, draft.size() - 1);
      case (fault)
         FAULT_DROP:
            if (draft.size() > 1) draft.delete(at);
            else draft.insert(draft.size(), delim_q);
         FAULT_EXTRA:        draft.insert(at, b64_char($urandom_range(0, 63)));
         FAULT_BYTE:         draft[at] = 8'($urandom_range(0, 255));
         FAULT_TRAIL_DELIM:  draft.insert(draft.size(), delim_q);
         FAULT_EARLY_MARKER:
            if (draft.size() > 2) draft[1] = marker_q;
            else draft[at] = marker_q;
         FAULT_SPLIT:        draft.insert(at, delim_q);
         default: ;
      endcase
   endtask

   // Short run of raw bytes, with the delimiter and marker mixed in.
   task automatic draft_noise();
      int len;
      int pick;
      len = $urandom_range(1, 6);
      draft.delete();
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) draft.insert(draft.size(), delim_q);
         else if (pick < 3) draft.insert(draft.size(), marker_q);
         else draft.insert(draft.size(), 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic queue_token(input token_kind_type kind);
      case (kind)
         TOKEN_GOOD:   draft_good();
         TOKEN_BROKEN: begin
            draft_good();
            break_draft();
         end
         default:      draft_noise();
      endcase
      for (int i = 0; i < draft.size(); i++) queue_char(draft[i], i == draft.size() - 1);
   endtask

   task automatic queue_random(input int n_chars, input bit good_only);
      int target;
      int pick;
      target = chars_loaded + n_chars;
      while (chars_loaded < target) begin
         pick = $urandom_range(0, 9);
         if (good_only || pick < 7) queue_token(TOKEN_GOOD);
         else if (pick < 9) queue_token(TOKEN_BROKEN);
         else queue_token(TOKEN_NOISE);
      end
   endtask

   // Wait until every char is taken and every couplet seen, then let the pipe drain.
   task automatic settle();
      wait (chars_taken == chars_loaded && results_taken == results_predicted);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ctp_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ctp_pkg::CHAR_W-1:0] value);
      int seen;
      @(posedge clock);
      seen = csr_beats;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      wait (csr_beats != seen);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [ctp_pkg::CHAR_W-1:0] delim,
                            input logic [ctp_pkg::CHAR_W-1:0] marker);
      write_csr(ctp_pkg::CSR_DELIMITER, delim);
      write_csr(ctp_pkg::CSR_MARKER, marker);
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed tokens with the reset delimiter '.' and marker '*'
      queue_text("Az");        // full last part
      queue_text("__.9-");     // part closed by delimiter, top indexes
      queue_text("A*");        // partial last part
      queue_text("A*.Bc");     // marker before a delimiter, rest ignored
      queue_text("A");         // part too short
      queue_text("ABC");       // part too long
      queue_text("A!");        // char outside the alphabet
      queue_text("AB.");       // delimiter as final char
      queue_char(8'h00, 1'b0); // raw byte extremes
      queue_char(8'hFF, 1'b1);
      queue_random(120, 1'b0);
      settle();

      // extremes of both registers
      configure(8'h00, 8'hFF);
      queue_random(PHASE_CHARS, 1'b0);
      settle();

      // no idling on either side
      send_idle_max = 0;
      recv_idle_max = 0;
      configure(8'hFF, 8'h00);
      queue_random(PHASE_CHARS, 1'b0);
      settle();

      // delimiter and marker both inside the alphabet
      send_idle_max = 5;
      recv_idle_max = 13;
      configure("_", "-");
      queue_random(PHASE_CHARS, 1'b0);
      settle();

      // delimiter equal to the marker; an unmapped index must change nothing
      send_idle_max = 13;
      recv_idle_max = 0;
      configure("A", "A");
      write_csr(CSR_UNUSED, 8'hA5);
      queue_random(PHASE_CHARS, 1'b0);
      settle();

      // pressure: sender at full rate, long hold-off on rsp
      send_idle_max = 0;
      recv_idle_max = 3;
      configure(",", "~");
      queue_random(PHASE_CHARS, 1'b1);
      pressure_go = 1'b1;
      settle();

      send_idle_max = 13;
      recv_idle_max = 13;
      configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      queue_random(PHASE_CHARS, 1'b0);
      settle();

      // back to the reset values
      recv_idle_max = 5;
      configure(ctp_pkg::DELIMITER_RESET, ctp_pkg::MARKER_RESET);
      queue_random(PHASE_CHARS, 1'b0);
      settle();

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
